### rtl/tccw_pkg.sv
// ============================================================================
// tccw_pkg
// Shared constants, types and command/status structs of the text console
// character writer.
// ============================================================================
package tccw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHR_W  = 8;
    localparam int CELL_W = 2 * CHR_W;

    localparam int CFG_IDX_W = 2;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

    localparam logic [CHR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHR_W-1:0] CH_CR  = 8'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_GLYPH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COLOR = 2'd2;

    localparam logic [CHR_W-1:0] RST_TEXT_ATTR    = 8'd7;
    localparam logic [CHR_W-1:0] RST_CURSOR_GLYPH = 8'd95;
    localparam logic [CHR_W-1:0] RST_CURSOR_COLOR = 8'd7;

    // Source of the cell memory read address.
    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_ACCEPT = 2'd1,
        RD_WRITE  = 2'd2,
        RD_SWEEP  = 2'd3
    } t_rd_sel;

    // Kind of cell memory write.
    typedef enum logic [2:0] {
        WR_NONE        = 3'd0,
        WR_SHOWN_ATTR0 = 3'd1,
        WR_CHAR        = 3'd2,
        WR_BS_ATTR0    = 3'd3,
        WR_CURSOR      = 3'd4,
        WR_SWEEP       = 3'd5
    } t_wr_sel;

    // Update of the write position.
    typedef enum logic [1:0] {
        POS_NONE   = 2'd0,
        POS_CODE   = 2'd1,
        POS_BACK   = 2'd2,
        POS_SCROLL = 2'd3
    } t_pos_op;

    typedef struct packed {
        logic    latch;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_pos_op pos_op;
        logic    sweep_clr;
        logic    sweep_run;
        logic    sweep_blank;
        logic    load_read;
        logic    load_put;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_read;
        logic bs_active;
        logic printable;
        logic row_over;
        logic sweep_end;
    } t_dp_stat;

endpackage

### rtl/tccw_ram.sv
// ============================================================================
// tccw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tccw_dp.sv
// ============================================================================
// tccw_dp
// Datapath: write and cursor position, configuration registers, cell memory
// address and data selection, sweep counter and result registers.
// ============================================================================
module tccw_dp
    import tccw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd_dp,
    output t_dp_stat             o_stat,
    input  logic                 i_cmd,
    input  logic [CHR_W-1:0]     i_char_code,
    input  logic [COL_W-1:0]     i_read_col,
    input  logic [ROW_W-1:0]     i_read_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHR_W-1:0]     i_cfg_data,
    output logic                 o_mem_we,
    output logic [ADDR_W-1:0]    o_mem_waddr,
    output logic [CELL_W-1:0]    o_mem_wdata,
    output logic [ADDR_W-1:0]    o_mem_raddr,
    input  logic [CELL_W-1:0]    i_mem_rdata,
    output logic [CHR_W-1:0]     o_cell_char,
    output logic [CHR_W-1:0]     o_cell_attr,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic                 o_scrolled
);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] r);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
        return a;
    endfunction

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_shown_col;
    logic [ROW_W-1:0] r_shown_row;
    logic [CHR_W-1:0] r_text_attr, r_cursor_glyph, r_cursor_color;
    logic [CHR_W-1:0] r_ch;
    logic             r_in_range;
    logic             r_scrolled;
    logic [CNT_W-1:0] r_cnt;

    logic [CHR_W-1:0] r_cell_char, r_cell_attr;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_scrolled;

    logic             in_range;
    logic [COL_W:0]   col_inc;
    logic [COL_W:0]   col_tab;
    logic [ROW_W-1:0] row_inc;
    logic [CNT_W:0]   sweep_src;
    logic [CNT_W-1:0] sweep_dst;
    logic             sweep_tail;

    assign in_range = (i_read_col < COL_W'(COLUMNS)) && (i_read_row < ROW_W'(ROWS));

    assign col_inc = {1'b0, r_col} + (COL_W+1)'(1);
    assign col_tab = {1'b0, r_col} - (COL_W+1)'(r_col % TAB_WIDTH)
                     + (COL_W+1)'(TAB_WIDTH);
    assign row_inc = r_row + ROW_W'(1);

    assign sweep_src  = (CNT_W+1)'(r_cnt) + (CNT_W+1)'(COLUMNS);
    assign sweep_dst  = r_cnt - CNT_W'(1);
    assign sweep_tail = sweep_dst >= CNT_W'(CELLS - COLUMNS);

    // Status to the controller.
    always_comb begin
        o_stat.acc_read  = i_cmd;
        o_stat.bs_active = (r_ch == CH_BS) && (r_col != '0);
        o_stat.printable = (r_ch != CH_BS) && (r_ch != CH_TAB) &&
                           (r_ch != CH_NL) && (r_ch != CH_CR);
        o_stat.row_over  = r_row >= ROW_W'(ROWS);
        o_stat.sweep_end = r_cnt == CNT_W'(CELLS);
    end

    // Next write position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_cmd_dp.pos_op)
            POS_CODE: begin
                case (r_ch)
                    CH_NL: begin
                        n_col = '0;
                        n_row = row_inc;
                    end
                    CH_CR: begin
                        n_col = '0;
                    end
                    CH_BS: begin
                        // Backspace at column 0 leaves the position alone.
                        n_col = r_col;
                    end
                    CH_TAB: begin
                        if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                            n_col = '0;
                            n_row = row_inc;
                        end else begin
                            n_col = col_tab[COL_W-1:0];
                        end
                    end
                    default: begin
                        if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                            n_col = '0;
                            n_row = row_inc;
                        end else begin
                            n_col = col_inc[COL_W-1:0];
                        end
                    end
                endcase
            end
            POS_BACK:   n_col = r_col - COL_W'(1);
            POS_SCROLL: n_row = ROW_W'(ROWS - 1);
            default:    n_col = r_col;
        endcase
    end

    // Cell memory read address.
    always_comb begin
        unique case (i_cmd_dp.rd_sel)
            RD_ACCEPT: begin
                if (i_cmd) begin
                    o_mem_raddr = in_range ? cell_addr(i_read_col, i_read_row) : '0;
                end else begin
                    o_mem_raddr = cell_addr(r_shown_col, r_shown_row);
                end
            end
            RD_WRITE: o_mem_raddr = cell_addr(r_col, r_row);
            RD_SWEEP: begin
                o_mem_raddr = (sweep_src < (CNT_W+1)'(CELLS)) ? ADDR_W'(sweep_src) : '0;
            end
            default:  o_mem_raddr = '0;
        endcase
    end

    // Cell memory write port.
    always_comb begin
        o_mem_we    = 1'b1;
        o_mem_waddr = cell_addr(r_col, r_row);
        o_mem_wdata = BLANK_CELL;
        unique case (i_cmd_dp.wr_sel)
            WR_SHOWN_ATTR0: begin
                o_mem_waddr = cell_addr(r_shown_col, r_shown_row);
                o_mem_wdata = {CHR_W'(0), i_mem_rdata[CHR_W-1:0]};
            end
            WR_CHAR:     o_mem_wdata = {r_text_attr, r_ch};
            WR_BS_ATTR0: o_mem_wdata = {CHR_W'(0), i_mem_rdata[CHR_W-1:0]};
            WR_CURSOR:   o_mem_wdata = {r_cursor_color, r_cursor_glyph};
            WR_SWEEP: begin
                // Each write lands in the cycle after its read; the bottom row gets blanks.
                o_mem_we    = r_cnt != '0;
                o_mem_waddr = ADDR_W'(sweep_dst);
                o_mem_wdata = (i_cmd_dp.sweep_blank || sweep_tail) ? BLANK_CELL
                                                                    : i_mem_rdata;
            end
            default: o_mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_shown_col    <= '0;
            r_shown_row    <= '0;
            r_text_attr    <= RST_TEXT_ATTR;
            r_cursor_glyph <= RST_CURSOR_GLYPH;
            r_cursor_color <= RST_CURSOR_COLOR;
            r_cnt          <= '0;
            r_scrolled     <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cmd_dp.load_put) begin
                r_shown_col <= r_col;
                r_shown_row <= r_row;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TEXT_ATTR:    r_text_attr    <= i_cfg_data;
                    CFG_CURSOR_GLYPH: r_cursor_glyph <= i_cfg_data;
                    CFG_CURSOR_COLOR: r_cursor_color <= i_cfg_data;
                    default:          r_text_attr    <= r_text_attr;
                endcase
            end
            if (i_cmd_dp.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd_dp.sweep_run && (r_cnt != CNT_W'(CELLS))) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd_dp.latch) begin
                r_scrolled <= 1'b0;
            end else if (i_cmd_dp.pos_op == POS_SCROLL) begin
                r_scrolled <= 1'b1;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.latch) begin
            r_ch       <= i_char_code;
            r_in_range <= in_range;
        end
        if (i_cmd_dp.load_read) begin
            r_cell_char    <= r_in_range ? i_mem_rdata[CHR_W-1:0] : '0;
            r_cell_attr    <= r_in_range ? i_mem_rdata[CELL_W-1:CHR_W] : '0;
            r_out_col      <= r_col;
            r_out_row      <= r_row;
            r_out_scrolled <= 1'b0;
        end else if (i_cmd_dp.load_put) begin
            r_cell_char    <= '0;
            r_cell_attr    <= '0;
            r_out_col      <= r_col;
            r_out_row      <= r_row;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_cell_char  = r_cell_char;
    assign o_cell_attr  = r_cell_attr;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scrolled;

endmodule

### rtl/tccw_ctrl.sv
// ============================================================================
// tccw_ctrl
// Controller: sequences the clearing pass, cell reads, the read-modify-write
// steps of a put, the scroll sweep and the result strobe.
// ============================================================================
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd_dp,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_READ   = 9'b000000100,
        S_SHOWN  = 9'b000001000,
        S_CODE   = 9'b000010000,
        S_BS     = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_SCROLL = 9'b010000000,
        S_CURSOR = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        o_cmd_dp = '{latch: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, pos_op: POS_NONE,
                     sweep_clr: 1'b0, sweep_run: 1'b0, sweep_blank: 1'b0,
                     load_read: 1'b0, load_put: 1'b0};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd_dp.rd_sel      = RD_SWEEP;
                o_cmd_dp.wr_sel      = WR_SWEEP;
                o_cmd_dp.sweep_run   = 1'b1;
                o_cmd_dp.sweep_blank = 1'b1;
                if (i_stat.sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // The read for the item is issued in its accept cycle.
                o_cmd_dp.rd_sel = RD_ACCEPT;
                o_cmd_dp.latch  = start;
                if (start) begin
                    n_state = i_stat.acc_read ? S_READ : S_SHOWN;
                end
            end
            S_READ: begin
                o_cmd_dp.load_read = 1'b1;
                n_valid            = 1'b1;
                n_state            = S_IDLE;
            end
            S_SHOWN: begin
                o_cmd_dp.wr_sel = WR_SHOWN_ATTR0;
                n_state         = S_CODE;
            end
            S_CODE: begin
                if (i_stat.bs_active) begin
                    o_cmd_dp.rd_sel = RD_WRITE;
                    n_state         = S_BS;
                end else begin
                    o_cmd_dp.wr_sel = i_stat.printable ? WR_CHAR : WR_NONE;
                    o_cmd_dp.pos_op = POS_CODE;
                    n_state         = S_CHECK;
                end
            end
            S_BS: begin
                o_cmd_dp.wr_sel = WR_BS_ATTR0;
                o_cmd_dp.pos_op = POS_BACK;
                n_state         = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.row_over) begin
                    o_cmd_dp.pos_op    = POS_SCROLL;
                    o_cmd_dp.sweep_clr = 1'b1;
                    n_state            = S_SCROLL;
                end else begin
                    n_state = S_CURSOR;
                end
            end
            S_SCROLL: begin
                o_cmd_dp.rd_sel    = RD_SWEEP;
                o_cmd_dp.wr_sel    = WR_SWEEP;
                o_cmd_dp.sweep_run = 1'b1;
                if (i_stat.sweep_end) begin
                    n_state = S_CURSOR;
                end
            end
            S_CURSOR: begin
                o_cmd_dp.wr_sel   = WR_CURSOR;
                o_cmd_dp.load_put = 1'b1;
                n_valid           = 1'b1;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_valid;

endmodule

### rtl/text_console_char_writer_core.sv
// ============================================================================
// text_console_char_writer_core
// 80x25 text console: put and read items on a character cell store.
// ============================================================================
// After reset the block runs a clearing pass over the cell memory with busy
// high. An item is taken when start is high and busy is low, and its result
// appears for one cycle with o_valid. A read item has its result registered
// from the cell memory read data in the S_READ state after the accept. A put
// steps through S_SHOWN, S_CODE, S_BS (for a backspace that erases), S_CHECK
// and S_CURSOR, and a put that scrolls adds the S_SCROLL sweep that copies
// every cell up one row through the single write port of the cell memory.
// The cycle that shows a result may already take the next item; results must
// be captured as they appear.
module text_console_char_writer_core
    import tccw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [CHR_W-1:0]     i_char_code,
    input  logic [COL_W-1:0]     i_read_col,
    input  logic [ROW_W-1:0]     i_read_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHR_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [CHR_W-1:0]     o_cell_char,
    output logic [CHR_W-1:0]     o_cell_attr,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic                 o_scrolled
);

    t_dp_cmd           cmd_dp;
    t_dp_stat          stat_dp;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tccw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_stat   (stat_dp),
        .o_cmd_dp (cmd_dp),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    tccw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_dp     (cmd_dp),
        .o_stat       (stat_dp),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while the block is busy");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_scroll_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cursor_row == ROW_W'(ROWS - 1)))
        else $error("scrolled put did not leave the cursor on the bottom row");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_cursor_col < COL_W'(COLUMNS)) && (o_cursor_row < ROW_W'(ROWS))))
        else $error("cursor position off the screen");

endmodule

### bench/tb_text_console_char_writer_core.sv
// ============================================================================
// Testbench for the text console character writer
// Puts characters and reads cells back on the 80x25 console. A scoreboard
// keeps its own copy of the cell store and write position, predicts every
// result and compares it field by field. Stimulus is a short directed list
// followed by random text, control codes and reads under several register
// settings and sender idle patterns.
// ============================================================================
module tb_text_console_char_writer_core
    import tccw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 325;
    localparam int LIMIT_CYCLES = 12_000_000;

    typedef struct packed {
        logic [CHR_W-1:0] chr;
        logic [CHR_W-1:0] attr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             scrolled;
    } t_console_result;

    // Keeps a shadow of the console and the results still owed by the block.
    class t_console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int                wr_col;
        int                wr_row;
        int                shown_col;
        int                shown_row;
        logic [CHR_W-1:0]  text_attr;
        logic [CHR_W-1:0]  glyph;
        logic [CHR_W-1:0]  color;
        t_console_result   owed_q [$];
        int                errors;
        int                puts;
        int                reads;
        int                scrolls;

        function new();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            wr_col    = 0;
            wr_row    = 0;
            shown_col = 0;
            shown_row = 0;
            text_attr = RST_TEXT_ATTR;
            glyph     = RST_CURSOR_GLYPH;
            color     = RST_CURSOR_COLOR;
            errors    = 0;
            puts      = 0;
            reads     = 0;
            scrolls   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CHR_W-1:0] val);
            case (idx)
                CFG_TEXT_ATTR:    text_attr = val;
                CFG_CURSOR_GLYPH: glyph     = val;
                CFG_CURSOR_COLOR: color     = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void wrap_line();
            if (wr_col >= COLUMNS) begin
                wr_col = 0;
                wr_row++;
            end
        endfunction

        function void note_item(logic cmd, logic [CHR_W-1:0] ch,
                                logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
            t_console_result r;
            int              at;
            r = '0;
            if (cmd == CMD_READ) begin
                reads++;
                if (rc < COLUMNS && rr < ROWS) begin
                    {r.attr, r.chr} = cells[rr * COLUMNS + rc];
                end
            end else begin
                puts++;
                // The old cursor cell loses its color before anything moves.
                cells[shown_row * COLUMNS + shown_col][CELL_W-1:CHR_W] = '0;
                at = wr_row * COLUMNS + wr_col;
                case (ch)
                    CH_NL: begin
                        wr_col = 0;
                        wr_row++;
                    end
                    CH_BS: begin
                        if (wr_col != 0) begin
                            cells[at][CELL_W-1:CHR_W] = '0;
                            wr_col--;
                        end
                    end
                    CH_TAB: begin
                        wr_col = wr_col + TAB_WIDTH - (wr_col % TAB_WIDTH);
                        wrap_line();
                    end
                    CH_CR: wr_col = 0;
                    default: begin
                        cells[at] = {text_attr, ch};
                        wr_col++;
                        wrap_line();
                    end
                endcase
                if (wr_row >= ROWS) begin
                    for (int i = 0; i < CELLS; i++) begin
                        cells[i] = (i + COLUMNS < CELLS) ? cells[i + COLUMNS] : BLANK_CELL;
                    end
                    wr_row     = ROWS - 1;
                    r.scrolled = 1'b1;
                    scrolls++;
                end
                shown_col = wr_col;
                shown_row = wr_row;
                cells[shown_row * COLUMNS + shown_col] = {color, glyph};
            end
            r.col = COL_W'(wr_col);
            r.row = ROW_W'(wr_row);
            owed_q.push_back(r);
        endfunction

        function void check_result(t_console_result got);
            t_console_result want;
            if (owed_q.size() == 0) begin
                $error("result with no item outstanding: %p", got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.chr !== want.chr) begin
                $error("cell_char: expected %0d, actual %0d", want.chr, got.chr);
                errors++;
            end
            if (got.attr !== want.attr) begin
                $error("cell_attr: expected %0d, actual %0d", want.attr, got.attr);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("cursor_col: expected %0d, actual %0d", want.col, got.col);
                errors++;
            end
            if (got.row !== want.row) begin
                $error("cursor_row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.scrolled !== want.scrolled) begin
                $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 i_cmd       = CMD_PUT;
    logic [CHR_W-1:0]     i_char_code = '0;
    logic [COL_W-1:0]     i_read_col  = '0;
    logic [ROW_W-1:0]     i_read_row  = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CHR_W-1:0]     i_cfg_data  = '0;
    logic                 o_valid;
    logic [CHR_W-1:0]     o_cell_char;
    logic [CHR_W-1:0]     o_cell_attr;
    logic [COL_W-1:0]     o_cursor_col;
    logic [ROW_W-1:0]     o_cursor_row;
    logic                 o_scrolled;

    t_console_scoreboard board = new();
    int                  cycles = 0;
    int                  settings = 1;

    text_console_char_writer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("text_console_char_writer_core: mismatch");
            $finish;
        end
    end

    // A result shown in the same cycle that takes a new item belongs to an
    // older item, so it is checked before the new item is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                board.check_result({o_cell_char, o_cell_attr, o_cursor_col,
                                    o_cursor_row, o_scrolled});
            end
            if (start && !busy) begin
                board.note_item(i_cmd, i_char_code, i_read_col, i_read_row);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [CHR_W-1:0] ch,
                             input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr,
                             input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= ch;
        i_read_col  <= rc;
        i_read_row  <= rr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic put_char(input logic [CHR_W-1:0] ch);
        send_item(CMD_PUT, ch, COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)), 0);
    endtask

    task automatic read_cell(input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        send_item(CMD_READ, CHR_W'($urandom_range(255)), rc, rr, 0);
    endtask

    task automatic send_random_item(input int idle_pct);
        int               roll;
        logic             cmd;
        logic [CHR_W-1:0] ch;
        logic [COL_W-1:0] rc;
        logic [ROW_W-1:0] rr;
        roll = $urandom_range(99);
        ch   = CHR_W'($urandom_range(255));
        rc   = COL_W'($urandom_range(127));
        rr   = ROW_W'($urandom_range(31));
        if (roll < 35) begin
            cmd  = CMD_READ;
            roll = $urandom_range(99);
            if (roll < 60) begin
                rc = COL_W'($urandom_range(COLUMNS - 1));
                rr = ROW_W'($urandom_range(ROWS - 1));
            end else if (roll < 85) begin
                // Around the write position, where the recent changes are.
                rc = COL_W'(board.wr_col);
                rr = ROW_W'(board.wr_row);
                if (rc != 0 && roll < 72) rc = rc - COL_W'(1);
            end
        end else begin
            cmd  = CMD_PUT;
            roll = $urandom_range(99);
            if (roll < 8)       ch = CH_NL;
            else if (roll < 14) ch = CH_TAB;
            else if (roll < 19) ch = CH_BS;
            else if (roll < 23) ch = CH_CR;
        end
        send_item(cmd, ch, rc, rr, idle_pct);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHR_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic write_regs(input logic [CHR_W-1:0] attr, input logic [CHR_W-1:0] glyph,
                              input logic [CHR_W-1:0] color);
        write_reg(CFG_TEXT_ATTR, attr);
        write_reg(CFG_CURSOR_GLYPH, glyph);
        write_reg(CFG_CURSOR_COLOR, color);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        int idle_pct [PHASES];
        idle_pct = '{0, 55, 12, 0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset values of the registers.
        read_cell(0, 0);
        put_char(8'h48);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BS);
        read_cell(2, 0);
        read_cell(1, 0);
        put_char(CH_CR);
        put_char(CH_BS);
        // Nine tabs reach the last tab stop, the tenth wraps to the next row.
        repeat (10) put_char(CH_TAB);
        put_char(CH_NL);
        read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        read_cell(7'd127, 5'd31);
        read_cell(COL_W'(COLUMNS), 0);
        read_cell(0, ROW_W'(ROWS));
        put_char(8'h7F);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: write_regs(8'h00, 8'h00, 8'h00);
                1: write_regs(8'hFF, 8'hFF, 8'hFF);
                default: write_regs(CHR_W'($urandom_range(255)), CHR_W'($urandom_range(255)),
                                    CHR_W'($urandom_range(255)));
            endcase
            repeat (PHASE_ITEMS) send_random_item(idle_pct[p]);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d puts (%0d of them scrolled) and %0d reads", board.puts,
                 board.scrolls, board.reads);
        $display("under %0d register settings and four phases of sender idling.", settings);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("text_console_char_writer_core: match");
        end else begin
            $display("text_console_char_writer_core: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_dp.sv
rtl/tccw_ctrl.sv
rtl/text_console_char_writer_core.sv
bench/tb_text_console_char_writer_core.sv
